FILE: rtl/core/nic_pkg.sv
// shared types, constants and saturating helpers for the newton coefficient block
package nic_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam logic signed [63:0] Q_ONE = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [63:0] MAG_CAP = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] coefficient;
    logic [3:0]         degree;
    logic               divide_error;
    logic               last_coefficient;
  } out_item_t;

  function automatic logic [63:0] mag_of(input logic signed [63:0] v);
    mag_of = v[63] ? (64'd0 - 64'(v)) : 64'(v);
  endfunction

  // magnitude is at most 2^63; apply sign and clamp
  function automatic logic signed [63:0] sat_mag(input logic neg, input logic [63:0] m);
    if (neg) begin
      sat_mag = 64'sd0 - $signed(m);
    end else begin
      sat_mag = m[63] ? Q_MAX : $signed(m);
    end
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add = s[64] ? Q_MIN : Q_MAX;
    end else begin
      sat_add = s[63:0];
    end
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      sat_sub = s[64] ? Q_MIN : Q_MAX;
    end else begin
      sat_sub = s[63:0];
    end
  endfunction

endpackage

FILE: rtl/core/nic_mul.sv
// q32.32 saturating multiplier, one 32x32 partial product per cycle
module nic_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic               busy,
  output logic signed [63:0] prod
);

  logic [63:0] ma, mb;
  logic        neg;
  logic [2:0]  step;
  logic [63:0] pr;
  logic [65:0] acc;
  logic        ovf;
  logic [31:0] op_a, op_b;

  // partial products: lo*lo, hi*lo, lo*hi, hi*hi
  always_comb begin
    op_a = step[0] ? ma[63:32] : ma[31:0];
    op_b = step[1] ? mb[63:32] : mb[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
      neg  <= a[63] ^ b[63];
      ma   <= nic_pkg::mag_of(a);
      mb   <= nic_pkg::mag_of(b);
      acc  <= '0;
      ovf  <= 1'b0;
    end else if (busy) begin
      step <= step + 3'd1;
      if (step < 3'd4) begin
        pr <= op_a * op_b;
      end
      unique case (step)
        3'd1: acc <= acc + 66'(pr[63:32]);
        3'd2, 3'd3: acc <= acc + 66'(pr);
        3'd4: begin
          if (pr >= 64'h8000_0000) begin
            ovf <= 1'b1;
          end else begin
            acc <= acc + {2'b00, pr[31:0], 32'd0};
          end
        end
        3'd5: begin
          busy <= 1'b0;
          prod <= nic_pkg::sat_mag(neg, (ovf || acc >= 66'(nic_pkg::MAG_CAP)) ?
                                        nic_pkg::MAG_CAP : acc[63:0]);
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/nic_div.sv
// q32.32 over q16.16 restoring divider, one quotient bit per cycle
module nic_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [32:0] den,
  output logic               busy,
  output logic signed [63:0] quot,
  output logic               zero_den
);

  localparam int QW = 80;
  localparam logic [6:0] STEPS = 7'(QW);

  logic [QW-1:0] dq;
  logic [32:0]   md;
  logic [32:0]   rem;
  logic          neg;
  logic [6:0]    cnt;
  logic [33:0]   trial;
  logic          fit;

  always_comb begin
    trial = {rem, dq[QW-1]};
    fit   = trial >= {1'b0, md};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= STEPS;
      neg      <= num[63] ^ den[32];
      dq       <= {nic_pkg::mag_of(num), 16'd0};
      md       <= den[32] ? (33'd0 - 33'(den)) : 33'(den);
      rem      <= '0;
      zero_den <= (den == 33'sd0);
    end else if (busy) begin
      if (cnt != 7'd0) begin
        cnt <= cnt - 7'd1;
        rem <= fit ? 33'(trial - {1'b0, md}) : trial[32:0];
        dq  <= {dq[QW-2:0], fit};
      end else begin
        busy <= 1'b0;
        if (zero_den) begin
          quot <= '0;
        end else begin
          quot <= nic_pkg::sat_mag(neg, (|dq[QW-1:63]) ? nic_pkg::MAG_CAP : dq[63:0]);
        end
      end
    end
  end

endmodule

FILE: rtl/core/newton_interpolation_coefficients_top.sv
// newton divided-difference interpolation: point loading, sequencer and stores
//
//   channel  | dir | payload               | handshake
//   in_data  | in  | x, y (q16.16), last   | in_valid / in_ready
//   out_data | out | coefficient, degree   | out_valid / out_ready
//
// each point item without the last flag is taken and leaves in_ready high
// after the last point: n(n-1)/2 divisions in the shared divider, then
// n(n+1)/2 + (n-1)(n+2)/2 products in the shared multiplier; coefficients
// leave one at a time, each read, loaded and held until out_ready
// in_ready is low from the last point until the final coefficient is taken
// synchronous reset clears the sequencer and point count; stores need none
module newton_interpolation_coefficients_top #(
  parameter int MAX_POINTS = nic_pkg::MAX_POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  nic_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output nic_pkg::out_item_t  out_data
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = $clog2(MAX_POINTS);

  // sequencer codes
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DD_R0   = 4'd1;
  localparam logic [3:0] S_DD_R1   = 4'd2;
  localparam logic [3:0] S_DD_R2   = 4'd3;
  localparam logic [3:0] S_DD_W    = 4'd4;
  localparam logic [3:0] S_EX_INIT = 4'd5;
  localparam logic [3:0] S_EC_R    = 4'd6;
  localparam logic [3:0] S_EC_M    = 4'd7;
  localparam logic [3:0] S_EC_W    = 4'd8;
  localparam logic [3:0] S_EB_R0   = 4'd9;
  localparam logic [3:0] S_EB_R1   = 4'd10;
  localparam logic [3:0] S_EB_R2   = 4'd11;
  localparam logic [3:0] S_EB_W    = 4'd12;
  localparam logic [3:0] S_OUT_R   = 4'd13;
  localparam logic [3:0] S_OUT_L   = 4'd14;
  localparam logic [3:0] S_OUT_W   = 4'd15;

  logic [3:0]       state;
  logic [CNT_W-1:0] cnt, n, i, j, k;
  logic             err;
  logic signed [63:0] acc_c, prev, d_a;
  logic signed [31:0] x_a;

  // stores: abscissae, divided differences, basis product, coefficients
  logic signed [31:0] x_mem [MAX_POINTS];
  logic signed [63:0] d_mem [MAX_POINTS];
  logic signed [63:0] b_mem [MAX_POINTS];
  logic signed [63:0] c_mem [MAX_POINTS];
  logic signed [31:0] x_rd;
  logic signed [63:0] d_rd, b_rd, c_rd;
  logic [IDX_W-1:0]   x_ra, d_ra, b_ra, c_ra, d_wa, b_wa, c_wa;
  logic               x_we, d_we, b_we, c_we;
  logic signed [63:0] d_wd, b_wd, c_wd;

  logic             in_fire, room;
  logic [CNT_W-1:0] n_load, i_inc, i_dec, j_dec, i_k;
  logic signed [63:0] xq;

  logic               mul_start, mul_busy;
  logic signed [63:0] mul_a, mul_b, mul_p;
  logic               div_start, div_busy, div_zero;
  logic signed [63:0] div_num, div_q;
  logic signed [32:0] div_den;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign room     = cnt < CNT_W'(MAX_POINTS);
  assign n_load   = room ? cnt + 1'b1 : cnt;
  assign i_inc    = i + 1'b1;
  assign i_dec    = i - 1'b1;
  assign j_dec    = j - 1'b1;
  assign i_k      = i - k;
  // abscissa as q32.32
  assign xq       = {{16{x_rd[31]}}, x_rd, 16'd0};

  // store read addressing by sequencer step
  always_comb begin
    x_ra = '0;
    d_ra = '0;
    b_ra = '0;
    c_ra = '0;
    unique case (state)
      S_DD_R0: begin
        d_ra = i[IDX_W-1:0];
        x_ra = i[IDX_W-1:0];
      end
      S_DD_R1: begin
        d_ra = i_dec[IDX_W-1:0];
        x_ra = i_k[IDX_W-1:0];
      end
      S_EC_R: begin
        d_ra = i[IDX_W-1:0];
        b_ra = j[IDX_W-1:0];
        c_ra = j[IDX_W-1:0];
      end
      S_EB_R0: begin
        b_ra = j[IDX_W-1:0];
        x_ra = i[IDX_W-1:0];
      end
      S_EB_R1: b_ra = j_dec[IDX_W-1:0];
      S_OUT_R: c_ra = j[IDX_W-1:0];
      default: ;
    endcase
  end

  always_comb begin
    x_we = in_fire && room;
    d_we = (in_fire && room) || (state == S_DD_W && !div_busy);
    d_wa = (state == S_IDLE) ? cnt[IDX_W-1:0] : i[IDX_W-1:0];
    d_wd = (state == S_IDLE) ? {{16{in_data.y_value[31]}}, in_data.y_value, 16'd0} : div_q;
    b_we = (state == S_EX_INIT) || (state == S_EB_W && !mul_busy);
    b_wa = (state == S_EX_INIT) ? '0 : j[IDX_W-1:0];
    b_wd = (state == S_EX_INIT) ? nic_pkg::Q_ONE : nic_pkg::sat_sub(prev, mul_p);
    c_we = (state == S_EC_W && !mul_busy);
    c_wa = j[IDX_W-1:0];
    // first touch of a coefficient starts from zero
    c_wd = (j == i) ? mul_p : nic_pkg::sat_add(acc_c, mul_p);
  end

  always_ff @(posedge clk) begin
    if (x_we) begin
      x_mem[cnt[IDX_W-1:0]] <= in_data.x_value;
    end
    if (d_we) begin
      d_mem[d_wa] <= d_wd;
    end
    if (b_we) begin
      b_mem[b_wa] <= b_wd;
    end
    if (c_we) begin
      c_mem[c_wa] <= c_wd;
    end
    x_rd <= x_mem[x_ra];
    d_rd <= d_mem[d_ra];
    b_rd <= b_mem[b_ra];
    c_rd <= c_mem[c_ra];
  end

  // shared arithmetic
  assign mul_start = (state == S_EC_M) || (state == S_EB_R1);
  assign mul_a     = (state == S_EC_M) ? d_rd : xq;
  // the top basis term is still zero before its first update
  assign mul_b     = (state == S_EC_M) ? b_rd : ((j == i_inc) ? 64'sd0 : b_rd);
  assign div_start = (state == S_DD_R2);
  assign div_num   = nic_pkg::sat_sub(d_a, d_rd);
  assign div_den   = {x_a[31], x_a} - {x_rd[31], x_rd};

  nic_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .prod  (mul_p)
  );

  nic_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (div_num),
    .den      (div_den),
    .busy     (div_busy),
    .quot     (div_q),
    .zero_den (div_zero)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      err       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            // the last point closes the set and clears the count
            cnt <= in_data.last_point ? '0 : n_load;
            if (in_data.last_point) begin
              n   <= n_load;
              err <= 1'b0;
              k   <= CNT_W'(1);
              i   <= n_load - 1'b1;
              state <= (n_load > CNT_W'(1)) ? S_DD_R0 : S_EX_INIT;
            end
          end
        end
        S_DD_R0: state <= S_DD_R1;
        S_DD_R1: begin
          d_a   <= d_rd;
          x_a   <= x_rd;
          state <= S_DD_R2;
        end
        S_DD_R2: state <= S_DD_W;
        S_DD_W: begin
          if (!div_busy) begin
            err <= err | div_zero;
            if (i > k) begin
              i     <= i_dec;
              state <= S_DD_R0;
            end else if (k + 1'b1 < n) begin
              k     <= k + 1'b1;
              i     <= n - 1'b1;
              state <= S_DD_R0;
            end else begin
              state <= S_EX_INIT;
            end
          end
        end
        S_EX_INIT: begin
          i     <= '0;
          j     <= '0;
          state <= S_EC_R;
        end
        S_EC_R: state <= S_EC_M;
        S_EC_M: begin
          acc_c <= c_rd;
          state <= S_EC_W;
        end
        S_EC_W: begin
          if (!mul_busy) begin
            if (j < i) begin
              j     <= j + 1'b1;
              state <= S_EC_R;
            end else if (i_inc < n) begin
              j     <= i_inc;
              state <= S_EB_R0;
            end else begin
              j     <= '0;
              state <= S_OUT_R;
            end
          end
        end
        S_EB_R0: state <= S_EB_R1;
        S_EB_R1: state <= S_EB_R2;
        S_EB_R2: begin
          prev  <= (j == '0) ? 64'sd0 : b_rd;
          state <= S_EB_W;
        end
        S_EB_W: begin
          if (!mul_busy) begin
            if (j != '0) begin
              j     <= j_dec;
              state <= S_EB_R0;
            end else begin
              i     <= i_inc;
              state <= S_EC_R;
            end
          end
        end
        S_OUT_R: state <= S_OUT_L;
        S_OUT_L: begin
          out_valid                 <= 1'b1;
          out_data.coefficient      <= c_rd;
          out_data.degree           <= 4'(j);
          out_data.divide_error     <= err;
          out_data.last_coefficient <= (j + 1'b1 == n);
          state                     <= S_OUT_W;
        end
        S_OUT_W: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (j + 1'b1 < n) begin
              j     <= j + 1'b1;
              state <= S_OUT_R;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // no new points while a coefficient is pending
  a_ready_no_out: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("input taken while result pending");

  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT_W) else $error("result valid outside output step");

  a_mul_free: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_busy) else $error("multiplier restarted while busy");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy) else $error("divider restarted while busy");

  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    div_start |=> div_busy) else $error("divider did not start");

endmodule

FILE: dv/tb.sv
// self-checking testbench for the newton interpolation coefficient block
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS = nic_pkg::MAX_POINTS_DEF;
  localparam logic signed [63:0] POS_CAP = nic_pkg::Q_MAX;
  localparam logic signed [63:0] NEG_CAP = nic_pkg::Q_MIN;

  // sender / receiver idling schemes, walked in order
  typedef enum int {IDLE_SEND_LIGHT, IDLE_RECV_LIGHT, IDLE_NONE} idle_scheme_e;

  // one row of directed stimulus; fixed rows carry a coefficient read off by hand
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               last;
    logic               fixed;
    logic signed [63:0] coef;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  nic_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  nic_pkg::out_item_t out_data;

  idle_scheme_e scheme = IDLE_SEND_LIGHT;
  int           fail_count = 0;
  int           hold_left = 0;

  // coefficients still to come, oldest first
  nic_pkg::out_item_t coef_expect_q[$];

  // predictor copy of the point store
  logic signed [31:0] pt_x[NPTS];
  logic signed [63:0] pt_y[NPTS];
  int                 pt_count = 0;

  newton_interpolation_coefficients_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // run limit, far above the slowest legal run
  initial begin
    #40ms;
    $display("FAIL newton_interpolation_coefficients_top");
    $finish;
  end

  task automatic report(input string what);
    fail_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // apply sign to a magnitude and clamp at the q32.32 range
  function automatic logic signed [63:0] signed_clamp(input logic neg, input logic [63:0] m);
    if (neg) return m[63] ? NEG_CAP : -$signed(m);
    return m[63] ? POS_CAP : $signed(m);
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  function automatic logic signed [63:0] add_clamp(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(POS_CAP)) return POS_CAP;
    if (s < 65'(NEG_CAP)) return NEG_CAP;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sub_clamp(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'(POS_CAP)) return POS_CAP;
    if (s < 65'(NEG_CAP)) return NEG_CAP;
    return s[63:0];
  endfunction

  // q32.32 product: upper part of the exact magnitude product
  function automatic logic signed [63:0] q_mul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic [127:0] p;
    logic [95:0]  r;
    p = 128'(abs64(a)) * 128'(abs64(b));
    r = p[127:32];
    if (r >= 96'h8000_0000_0000_0000) return signed_clamp(a[63] ^ b[63], nic_pkg::MAG_CAP);
    return signed_clamp(a[63] ^ b[63], r[63:0]);
  endfunction

  // q32.32 over q16.16 difference, truncated toward zero; zero divisor flags
  function automatic logic signed [63:0] q_div(input logic signed [63:0] num,
                                               input logic signed [63:0] den,
                                               inout logic err);
    logic [127:0] q;
    if (den == 0) begin
      err = 1'b1;
      return '0;
    end
    q = {48'd0, abs64(num), 16'd0} / 128'(abs64(den));
    if (q >= 128'h8000_0000_0000_0000) begin
      return signed_clamp(num[63] ^ den[63], nic_pkg::MAG_CAP);
    end
    return signed_clamp(num[63] ^ den[63], q[63:0]);
  endfunction

  // newton form of the stored points, multiplied out into monomial coefficients
  task automatic solve_coefficients();
    logic signed [63:0] dd[NPTS];
    logic signed [63:0] basis[NPTS+1];
    logic signed [63:0] cf[NPTS+1];
    logic signed [63:0] xq;
    logic               err;
    nic_pkg::out_item_t res;
    int                 n;
    err = 1'b0;
    n = pt_count;
    for (int i = 0; i < n; i++) dd[i] = pt_y[i];
    for (int k = 1; k < n; k++)
      for (int i = n - 1; i >= k; i--)
        dd[i] = q_div(sub_clamp(dd[i], dd[i-1]), 64'(pt_x[i]) - 64'(pt_x[i-k]), err);
    for (int j = 0; j <= NPTS; j++) begin
      cf[j] = '0;
      basis[j] = '0;
    end
    basis[0] = nic_pkg::Q_ONE;
    for (int i = 0; i < n; i++) begin
      xq = 64'(pt_x[i]) <<< 16;
      for (int j = 0; j <= i; j++) cf[j] = add_clamp(cf[j], q_mul(dd[i], basis[j]));
      if (i + 1 < n) begin
        for (int j = i + 1; j > 0; j--) basis[j] = sub_clamp(basis[j-1], q_mul(xq, basis[j]));
        basis[0] = sub_clamp(64'sd0, q_mul(xq, basis[0]));
      end
    end
    for (int j = 0; j < n; j++) begin
      res.coefficient = cf[j];
      res.degree = 4'(j);
      res.divide_error = err;
      res.last_coefficient = (j == n - 1);
      coef_expect_q.push_back(res);
    end
    pt_count = 0;
  endtask

  // predictor step for one accepted point
  task automatic take_point(input nic_pkg::in_item_t it, input logic fixed,
                            input logic signed [63:0] coef);
    nic_pkg::out_item_t res;
    if (pt_count < NPTS) begin
      pt_x[pt_count] = it.x_value;
      pt_y[pt_count] = 64'(it.y_value) <<< 16;
      pt_count++;
    end
    if (!it.last_point) return;
    if (fixed) begin
      // hand-computed single point rows
      res.coefficient = coef;
      res.degree = '0;
      res.divide_error = 1'b0;
      res.last_coefficient = 1'b1;
      coef_expect_q.push_back(res);
      pt_count = 0;
    end else begin
      solve_coefficients();
    end
  endtask

  function automatic int send_gap_pct();
    case (scheme)
      IDLE_SEND_LIGHT: return 9;
      IDLE_RECV_LIGHT: return 47;
      default:         return 0;
    endcase
  endfunction

  // offer one item at the falling edge and hold it until taken;
  // valid drops only when the sender idles or stops
  task automatic send_point(input nic_pkg::in_item_t it, input logic fixed = 1'b0,
                            input logic signed [63:0] coef = '0);
    while ($urandom_range(99) < send_gap_pct()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    take_point(it, fixed, coef);
    @(negedge clk);
  endtask

  // random abscissa: mostly moderate, sometimes full range
  function automatic logic signed [31:0] pick_x();
    if ($urandom_range(9) == 0) return $signed($urandom());
    return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
  endfunction

  function automatic logic signed [31:0] pick_y();
    if ($urandom_range(7) == 0) return $signed($urandom());
    return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
  endfunction

  // one set of random points; equal abscissae only when asked
  task automatic send_set(input int npts, input logic allow_dup);
    logic signed [31:0] xs[$];
    logic signed [31:0] xv;
    nic_pkg::in_item_t  it;
    for (int i = 0; i < npts; i++) begin
      do xv = pick_x(); while (!allow_dup && (xv inside {xs}));
      if (allow_dup && i > 0 && $urandom_range(2) == 0) xv = xs[$urandom_range(i - 1)];
      xs.push_back(xv);
      it.x_value = xv;
      it.y_value = pick_y();
      it.last_point = (i == npts - 1);
      send_point(it);
    end
  endtask

  // receiver: random stalls in the light idling schemes, plus a long hold-off when asked
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (scheme == IDLE_SEND_LIGHT) begin
      out_ready <= ($urandom_range(99) >= 47);
    end else if (scheme == IDLE_RECV_LIGHT) begin
      out_ready <= ($urandom_range(99) >= 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker, sampled at the rising edge
  always @(posedge clk) begin
    nic_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (coef_expect_q.size() == 0) begin
        report($sformatf("unexpected coefficient %h", out_data));
      end else begin
        want = coef_expect_q.pop_front();
        if (out_data.coefficient !== want.coefficient)
          report($sformatf("coefficient %h, want %h", out_data.coefficient, want.coefficient));
        if (out_data.degree !== want.degree)
          report($sformatf("degree %0d, want %0d", out_data.degree, want.degree));
        if (out_data.divide_error !== want.divide_error)
          report($sformatf("divide_error %b, want %b", out_data.divide_error,
                           want.divide_error));
        if (out_data.last_coefficient !== want.last_coefficient)
          report($sformatf("last_coefficient %b, want %b", out_data.last_coefficient,
                           want.last_coefficient));
      end
    end
  end

  dir_row_t dir_rows[] = '{
    // single points: y moved to q32.32 is the only coefficient
    '{32'sh0000_0000, 32'sh0000_0000, 1'b1, 1'b1, 64'sh0},
    '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 1'b1, 64'sh0000_7FFF_FFFF_0000},
    '{32'sh8000_0000, 32'sh8000_0000, 1'b1, 1'b1, 64'shFFFF_8000_0000_0000},
    // a line through two points
    '{32'sh0001_0000, 32'sh0003_0000, 1'b0, 1'b0, 64'sh0},
    '{32'sh0002_0000, 32'sh0005_0000, 1'b1, 1'b0, 64'sh0},
    // equal abscissae raise the divide error
    '{32'sh0001_8000, 32'sh0001_0000, 1'b0, 1'b0, 64'sh0},
    '{32'sh0001_8000, 32'shFFFF_0000, 1'b1, 1'b0, 64'sh0},
    // extreme abscissae and ordinates, saturating products
    '{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 1'b0, 64'sh0},
    '{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 1'b0, 64'sh0},
    '{32'sh0000_0001, 32'sh7FFF_FFFF, 1'b1, 1'b0, 64'sh0},
    // tiny spacing, huge slope
    '{32'sh0000_0000, 32'sh8000_0000, 1'b0, 1'b0, 64'sh0},
    '{32'sh0000_0001, 32'sh7FFF_FFFF, 1'b0, 1'b0, 64'sh0},
    '{32'sh0000_0002, 32'sh8000_0000, 1'b0, 1'b0, 64'sh0},
    '{32'shFFFF_FFFF, 32'sh0000_0001, 1'b1, 1'b0, 64'sh0}
  };

  initial begin
    nic_pkg::in_item_t it;
    int                sent;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part
    foreach (dir_rows[r]) begin
      it.x_value = dir_rows[r].x;
      it.y_value = dir_rows[r].y;
      it.last_point = dir_rows[r].last;
      send_point(it, dir_rows[r].fixed, dir_rows[r].coef);
    end
    // over-full set: points past the store size are dropped, last still counts
    for (int i = 0; i < NPTS + 3; i++) begin
      it.x_value = 32'(i) <<< 14;
      it.y_value = pick_y();
      it.last_point = (i == NPTS + 2);
      send_point(it);
    end

    // random part in three idling schemes
    sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      scheme = idle_scheme_e'(ph);
      if (ph == 2) begin
        // let the block drain completely before going on
        in_valid <= 1'b0;
        wait (coef_expect_q.size() == 0);
        @(negedge clk);
        // long receiver hold-off while points keep coming
        hold_left = 3000;
      end
      while (sent < 72 * (ph + 1)) begin
        int npts;
        case ($urandom_range(19))
          0:       npts = NPTS;
          1:       npts = NPTS + 1 + $urandom_range(2);
          2, 3:    npts = 1;
          default: npts = 2 + $urandom_range(4);
        endcase
        send_set(npts, $urandom_range(7) == 0);
        sent += npts;
      end
    end

    in_valid <= 1'b0;
    wait (coef_expect_q.size() == 0);
    repeat (200) @(negedge clk);
    if (fail_count == 0 && coef_expect_q.size() == 0) begin
      $display("PASS newton_interpolation_coefficients_top");
    end else begin
      $display("FAIL newton_interpolation_coefficients_top");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/nic_pkg.sv
rtl/core/nic_mul.sv
rtl/core/nic_div.sv
rtl/core/newton_interpolation_coefficients_top.sv
dv/tb.sv
